>>> sv/png_scanline_unfilter_assert.svh
// Assertion macros shared by the unfilter checker.
`ifndef PNG_SCANLINE_UNFILTER_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_ASSERT_SVH

// Plain property, sampled on the rising clock, off while reset is low.
`define PSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A stalled transfer keeps valid up and the payload unchanged.
`define PSU_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    ((vld) && !(rdy)) |=> ((vld) && $stable(sig))) else $error(msg);

`endif

>>> sv/psu_pkg.sv
// Types, constants and the filter predictor for the PNG scanline unfilter.
package psu_pkg;

  localparam int unsigned MaxWidth   = 4096;
  localparam int unsigned MaxChan    = 4;
  localparam int unsigned StoreDepth = MaxWidth * MaxChan;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned PosW       = AddrW + 1;
  localparam int unsigned WidthRegW  = 13;
  localparam int unsigned HeightW    = 16;
  localparam int unsigned ChanRegW   = 3;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [7:0] OpaqueAlpha = 8'hFF;
  localparam logic [7:0] MaxFilter   = 8'd4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgWidth    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHeight   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgChannels = 2'd2;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_e;

  // What a byte turns into once its place in the row is known
  typedef enum logic [1:0] {
    OP_FILTER = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_BAD    = 2'd2
  } op_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_image;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_argb;
    logic        bad_filter;
    logic        last_of_image;
  } out_item_t;

  typedef struct packed {
    logic [WidthRegW-1:0] width;
    logic [HeightW-1:0]   height;
    logic [ChanRegW-1:0]  chan;
  } cfg_t;

  // One byte handed from the sequencer to the reconstruction stage
  typedef struct packed {
    op_e                 op;
    logic [7:0]          data;
    filter_e             kind;
    logic [AddrW-1:0]    idx;
    logic [1:0]          chan;
    logic [ChanRegW-1:0] nchan;
    logic                first_row;
    logic                emit;
    logic                last;
  } entry_t;

  // Filter predictor: a left, b up, c up-left
  function automatic logic [7:0] predict(filter_e kind, logic [7:0] a, logic [7:0] b,
                                         logic [7:0] c);
    logic signed [9:0] p;
    logic signed [9:0] pa;
    logic signed [9:0] pb;
    logic signed [9:0] pc;
    logic [8:0]        sum;
    logic [7:0]        res;
    p   = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({2'b00, c});
    pa  = p - $signed({2'b00, a});
    pb  = p - $signed({2'b00, b});
    pc  = p - $signed({2'b00, c});
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    sum = {1'b0, a} + {1'b0, b};
    res = 8'd0;
    unique case (kind)
      FILT_SUB:   res = a;
      FILT_UP:    res = b;
      FILT_AVG:   res = sum[8:1];
      FILT_PAETH: begin
        if (pa <= pb && pa <= pc) res = a;
        else if (pb <= pc)        res = b;
        else                      res = c;
      end
      default:    res = 8'd0;
    endcase
    return res;
  endfunction

endpackage

>>> sv/psu_seq.sv
// Byte sequencer: row position, row count, filter byte checks and halt state.
module psu_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  psu_pkg::cfg_t              cfg_i,
  input  logic                       acc_i,
  input  psu_pkg::in_item_t          item_i,
  output logic                       ent_valid_o,
  output psu_pkg::entry_t            ent_o,
  output logic [psu_pkg::AddrW-1:0]  rd_addr_o
);

  logic [psu_pkg::PosW-1:0]      bp_q, bp_d, bp_eff, row_len;
  logic [1:0]                    m3_q, m3_d, m3_eff;
  logic [psu_pkg::HeightW-1:0]   row_q, row_d, row_eff;
  logic [psu_pkg::HeightW:0]     row_inc;
  psu_pkg::filter_e              kind_q, kind_d;
  logic                          halted_q, halted_d, halted_eff;
  logic [psu_pkg::WidthRegW-1:0] w_n;
  logic [psu_pkg::HeightW-1:0]   h_n;
  logic [psu_pkg::ChanRegW-1:0]  ch_n;
  logic [psu_pkg::AddrW-1:0]     idx;
  logic [1:0]                    chan;
  logic                          at_filter, end_of_row, last;

  // Clamp the registers to their legal ranges
  always_comb begin
    if (cfg_i.width == '0) w_n = psu_pkg::WidthRegW'(1);
    else if (cfg_i.width > psu_pkg::WidthRegW'(psu_pkg::MaxWidth))
      w_n = psu_pkg::WidthRegW'(psu_pkg::MaxWidth);
    else w_n = cfg_i.width;
    h_n = (cfg_i.height == '0) ? psu_pkg::HeightW'(1) : cfg_i.height;
    if (cfg_i.chan == '0) ch_n = psu_pkg::ChanRegW'(1);
    else if (cfg_i.chan > psu_pkg::ChanRegW'(psu_pkg::MaxChan))
      ch_n = psu_pkg::ChanRegW'(psu_pkg::MaxChan);
    else ch_n = cfg_i.chan;
  end

  assign row_len = psu_pkg::PosW'(w_n) * psu_pkg::PosW'(ch_n);

  // Start flag takes effect before the byte itself is looked at
  assign bp_eff     = item_i.start_of_image ? '0 : bp_q;
  assign m3_eff     = item_i.start_of_image ? 2'd0 : m3_q;
  assign row_eff    = item_i.start_of_image ? '0 : row_q;
  assign halted_eff = item_i.start_of_image ? 1'b0 : halted_q;

  assign at_filter  = (bp_eff == '0) || (bp_eff > row_len);
  assign end_of_row = (bp_eff >= row_len);
  assign idx        = psu_pkg::AddrW'(bp_eff - psu_pkg::PosW'(1));
  assign row_inc    = {1'b0, row_eff} + (psu_pkg::HeightW + 1)'(1);
  assign last       = end_of_row && (row_inc >= {1'b0, h_n});
  assign rd_addr_o  = idx;

  // Channel of this sample; m3 tracks the byte position modulo three
  always_comb begin
    unique case (ch_n)
      3'd1:    chan = 2'd0;
      3'd2:    chan = {1'b0, idx[0]};
      3'd3:    chan = (m3_eff == 2'd0) ? 2'd2 : m3_eff - 2'd1;
      default: chan = idx[1:0];
    endcase
  end

  // Entry for the reconstruction stage and next position
  always_comb begin
    bp_d        = bp_eff;
    m3_d        = m3_eff;
    row_d       = row_eff;
    kind_d      = kind_q;
    halted_d    = halted_eff;
    ent_valid_o = !halted_eff;
    ent_o.op        = psu_pkg::OP_SAMPLE;
    ent_o.data      = item_i.data_byte;
    ent_o.kind      = kind_q;
    ent_o.idx       = idx;
    ent_o.chan      = chan;
    ent_o.nchan     = ch_n;
    ent_o.first_row = (row_eff == '0);
    ent_o.emit      = ({1'b0, chan} + 3'd1) == ch_n;
    ent_o.last      = last;
    if (!halted_eff) begin
      if (at_filter) begin
        if (item_i.data_byte > psu_pkg::MaxFilter) begin
          ent_o.op = psu_pkg::OP_BAD;
          halted_d = 1'b1;
          bp_d     = '0;
        end else begin
          ent_o.op = psu_pkg::OP_FILTER;
          kind_d   = psu_pkg::filter_e'(item_i.data_byte[2:0]);
          bp_d     = psu_pkg::PosW'(1);
          m3_d     = 2'd1;
        end
      end else if (end_of_row) begin
        bp_d  = '0;
        m3_d  = 2'd0;
        row_d = last ? '0 : row_inc[psu_pkg::HeightW-1:0];
      end else begin
        bp_d = bp_eff + psu_pkg::PosW'(1);
        m3_d = (m3_eff == 2'd2) ? 2'd0 : m3_eff + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_q     <= '0;
      m3_q     <= 2'd0;
      row_q    <= '0;
      kind_q   <= psu_pkg::FILT_NONE;
      halted_q <= 1'b0;
    end else if (acc_i) begin
      bp_q     <= bp_d;
      m3_q     <= m3_d;
      row_q    <= row_d;
      kind_q   <= kind_d;
      halted_q <= halted_d;
    end
  end

endmodule

>>> sv/png_scanline_unfilter.sv
// PNG scanline unfilter top level: config, line store, reconstruction, output register.
//
//  channel | signals                                | payload
//  in      | in_valid_i / in_ready_o                | in_data_i  (data_byte, start_of_image)
//  out     | out_valid_o / out_ready_i              | out_data_o (pixel_argb, bad_filter, last)
//  cfg     | cfg_valid_i / cfg_ready_o              | cfg_index_i, cfg_data_i
//
// One byte is taken per cycle while the input is not stalled. A result is offered
// from the output register: the byte and its line store read are registered at
// the transfer, and the reconstruction loads the output register as stage 1 advances.
// Reset clears position, row count, neighbors and config (width 1, height 1,
// four channels); the line store is not cleared.
// A stalled output holds one result and one more byte; input stalls only then.
module png_scanline_unfilter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  psu_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output psu_pkg::out_item_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [psu_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [psu_pkg::CfgDataW-1:0]  cfg_data_i
);

  psu_pkg::cfg_t             cfg_q;
  logic                      acc, ent_valid;
  psu_pkg::entry_t           ent, s1_q;
  logic [psu_pkg::AddrW-1:0] rd_addr;
  logic                      s1_valid_q, s1_emit, s1_adv, wr_en;
  logic [7:0]                rdata_q;
  logic [7:0]                store [psu_pkg::StoreDepth];
  logic [7:0]                left_q [4];
  logic [7:0]                up_q [4];
  logic [7:0]                part_q [3];
  logic [7:0]                a, b, c, recon;
  logic [7:0]                al, r, g, bl;
  psu_pkg::out_item_t        res, out_q;
  logic                      out_valid_q;

  // Config writes, accepted every cycle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= psu_pkg::WidthRegW'(1);
      cfg_q.height <= psu_pkg::HeightW'(1);
      cfg_q.chan   <= psu_pkg::ChanRegW'(psu_pkg::MaxChan);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        psu_pkg::CfgWidth:    cfg_q.width  <= cfg_data_i[psu_pkg::WidthRegW-1:0];
        psu_pkg::CfgHeight:   cfg_q.height <= cfg_data_i[psu_pkg::HeightW-1:0];
        psu_pkg::CfgChannels: cfg_q.chan   <= cfg_data_i[psu_pkg::ChanRegW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: stage 1 moves unless it holds a result and the output is full and not ready
  assign s1_emit    = (s1_q.op == psu_pkg::OP_BAD) ||
                      ((s1_q.op == psu_pkg::OP_SAMPLE) && s1_q.emit);
  assign s1_adv     = s1_valid_q && (!s1_emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign acc        = in_valid_i && in_ready_o;
  assign wr_en      = s1_adv && (s1_q.op == psu_pkg::OP_SAMPLE);

  psu_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .acc_i       (acc),
    .item_i      (in_data_i),
    .ent_valid_o (ent_valid),
    .ent_o       (ent),
    .rd_addr_o   (rd_addr)
  );

  // Stage 1 valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else if (acc) s1_valid_q <= ent_valid;
    else if (s1_adv) s1_valid_q <= 1'b0;
  end

  // Stage 1 payload, line store read with it, reconstructed byte written back
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q    <= ent;
      rdata_q <= store[rd_addr];
    end
    if (wr_en) store[s1_q.idx] <= recon;
  end

  // Reconstruction
  assign a     = left_q[s1_q.chan];
  assign c     = up_q[s1_q.chan];
  assign b     = s1_q.first_row ? 8'd0 : rdata_q;
  assign recon = s1_q.data + psu_pkg::predict(s1_q.kind, a, b, c);

  // Left, upper-left and partial pixel bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) begin
        left_q[k] <= 8'd0;
        up_q[k]   <= 8'd0;
      end
      for (int k = 0; k < 3; k++) part_q[k] <= 8'd0;
    end else if (s1_adv) begin
      if (s1_q.op == psu_pkg::OP_FILTER) begin
        for (int k = 0; k < 4; k++) begin
          left_q[k] <= 8'd0;
          up_q[k]   <= 8'd0;
        end
        for (int k = 0; k < 3; k++) part_q[k] <= 8'd0;
      end else if (s1_q.op == psu_pkg::OP_SAMPLE) begin
        left_q[s1_q.chan] <= recon;
        up_q[s1_q.chan]   <= b;
        if (!s1_q.emit) begin
          for (int k = 0; k < 3; k++) begin
            if (s1_q.chan == 2'(k)) part_q[k] <= recon;
          end
        end
      end
    end
  end

  // Pixel assembly
  always_comb begin
    al = psu_pkg::OpaqueAlpha;
    r  = part_q[0];
    g  = part_q[1];
    bl = part_q[2];
    unique case (s1_q.nchan)
      3'd1: begin
        r  = recon;
        g  = recon;
        bl = recon;
      end
      3'd2: begin
        g  = part_q[0];
        bl = part_q[0];
        al = recon;
      end
      3'd3: bl = recon;
      default: al = recon;
    endcase
    if (s1_q.op == psu_pkg::OP_BAD) begin
      res.pixel_argb    = 32'd0;
      res.bad_filter    = 1'b1;
      res.last_of_image = 1'b0;
    end else begin
      res.pixel_argb    = {al, r, g, bl};
      res.bad_filter    = 1'b0;
      res.last_of_image = s1_q.last;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (s1_adv && s1_emit) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> sv/psu_checker.sv
// Port-level checker for the PNG scanline unfilter, bound to the top level.
`include "png_scanline_unfilter_assert.svh"

module psu_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input psu_pkg::out_item_t out_data_o
);

  // A waiting result stays put
  `PSU_ASSERT_HOLD(a_out_hold, out_valid_o, out_ready_i, out_data_o, "result changed while stalled")

  // An error result carries no pixel and no end mark
  `PSU_ASSERT(a_bad_form,
              (out_valid_o && out_data_o.bad_filter) |->
                ((out_data_o.pixel_argb == 32'd0) && !out_data_o.last_of_image),
              "malformed error result")

  // A new result follows an earlier input transfer
  `PSU_ASSERT(a_out_latency, $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2),
              "result without a matching input transfer")

  // With the output empty the input side never stalls
  `PSU_ASSERT(a_ready_empty, !out_valid_o |-> in_ready_o, "input stalled with empty output")

endmodule

bind png_scanline_unfilter psu_checker u_psu_checker (.*);
